// ===== rtl/mcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg: shared constants and tables for the month calendar grid
// Calendar constants, reciprocal constants for the shared multiplier and
// month tables used by the grid generator and its checker.
// ----------------------------------------------------------------------------
package mcg_pkg;

    // payload widths
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int WDAY_W    = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // grid shape
    localparam int GRID_CELLS = 42;
    localparam int CELL_W     = 6;

    // calendar anchor: 1 jan 1900 is a monday, 460 leap years in 1..1899
    localparam int BASE_YEAR         = 1900;
    localparam int LEAPS_BEFORE_BASE = 460;
    localparam int JAN1_OFFSET       = BASE_YEAR + LEAPS_BEFORE_BASE - 1;

    // weekday codes
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
    localparam int RECIP_100       = 5243;
    localparam int RECIP_100_SHIFT = 19;
    // floor(x / 7) = (x * 37450) >> 18, exact for x below 43690
    localparam int RECIP_7         = 37450;
    localparam int RECIP_7_SHIFT   = 18;

    // shared multiplier operand widths
    localparam int MUL_A_W = 15;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // days in a month, zero for codes that name no month
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                       input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the year before the first of the month, zero for bad codes
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month,
                                               input logic leap);
        logic [8:0] days;
        logic [8:0] extra;
        extra = (leap && month > 4'd2) ? 9'd1 : 9'd0;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        if (month > MONTH_DEC)
        begin
            extra = 9'd0;
        end
        return days + extra;
    endfunction

endpackage

// ===== rtl/month_calendar_grid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// month_calendar_grid: gregorian month calendar grid generator
// Takes a year and month and streams the 6 x 7 month grid, sunday first.
// ----------------------------------------------------------------------------
// Usage:
//   one request on the s_ channel carries a year and a month. The block
//   answers with 42 grid cells on the m_ channel, row by row, each holding a
//   day number (0 for a blank cell) and the weekday of the month's first day;
//   m_tlast marks the 42nd cell. A month code outside 1..12 gives a blank
//   grid with the weekday of january 1st.
//   Working order: the request is taken in idle, then the states ST_MUL_N,
//   ST_MUL_Y, ST_LEAP, ST_MUL_T and ST_REM make three passes through one
//   shared 15 x 16 multiplier (two divisions by 100 and one modulo 7, by
//   reciprocal), then the grid cells follow, one per cycle while m_tready
//   is high.
//   s_tready is high only while the block is idle; one request is in work
//   at a time.
//   A stall on m_tready holds the current cell; the sequence resumes when
//   the receiver takes it.
//   Reset returns the block to idle with no cell pending.
// ----------------------------------------------------------------------------
module month_calendar_grid
    import mcg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [13:0] year, [17:14] month, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] day_number, [7:5] first_weekday
    output logic                  m_tlast    // last_cell
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_Y,
        ST_LEAP,
        ST_MUL_T,
        ST_REM,
        ST_EMIT
    } state_t;

    state_t               state_reg,  state_next;
    logic [YEAR_W-1:0]    year_reg,   year_next;
    logic [MONTH_W-1:0]   month_reg,  month_next;
    logic [MUL_P_W-1:0]   prod_reg,   prod_next;
    logic [7:0]           qn_reg,     qn_next;
    logic [MUL_A_W-1:0]   total_reg,  total_next;
    logic [DAY_W-1:0]     len_reg,    len_next;
    logic [WDAY_W-1:0]    wday_reg,   wday_next;
    logic [CELL_W-1:0]    cell_reg,   cell_next;

    // shared multiplier
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;

    // leap and weekday arithmetic
    logic [7:0]           qy;
    logic [YEAR_W-1:0]    qy_x100;
    logic [YEAR_W-1:0]    year_m1;
    logic                 leap;
    logic [MUL_A_W-1:0]   leaps_n;
    logic [MUL_A_W-1:0]   jan1_sum;
    logic [12:0]          q7;
    logic [MUL_A_W-1:0]   q7_x7;
    logic [MUL_A_W-1:0]   rem7;

    // cell output
    logic [CELL_W-1:0]    diff;
    logic                 in_month;
    logic                 last;

    assign year_m1 = year_reg - 14'd1;

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_N:
            begin
                mul_a = MUL_A_W'(year_m1);
                mul_b = MUL_B_W'(RECIP_100);
            end
            ST_MUL_Y:
            begin
                mul_a = MUL_A_W'(year_reg);
                mul_b = MUL_B_W'(RECIP_100);
            end
            default:
            begin
                mul_a = total_reg;
                mul_b = MUL_B_W'(RECIP_7);
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // leap rule: century years need year / 100 divisible by 4
    assign qy      = prod_reg[RECIP_100_SHIFT +: 8];
    assign qy_x100 = (YEAR_W'(qy) << 6) + (YEAR_W'(qy) << 5) + (YEAR_W'(qy) << 2);
    assign leap    = (year_reg == qy_x100) ? (qy[1:0] == 2'd0) : (year_reg[1:0] == 2'd0);

    // leap years in 1..year-1, then day count from the anchor
    assign leaps_n  = MUL_A_W'(year_m1[YEAR_W-1:2]) - MUL_A_W'(qn_reg) + MUL_A_W'(qn_reg[7:2]);
    assign jan1_sum = (year_reg <= YEAR_W'(BASE_YEAR)) ? MUL_A_W'(1)
                    : MUL_A_W'(year_reg) + leaps_n - MUL_A_W'(JAN1_OFFSET);

    // remainder mod 7 from the reciprocal quotient
    assign q7    = prod_reg[RECIP_7_SHIFT +: 13];
    assign q7_x7 = (MUL_A_W'(q7) << 3) - MUL_A_W'(q7);
    assign rem7  = total_reg - q7_x7;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        year_next  = year_reg;
        month_next = month_reg;
        prod_next  = prod_reg;
        qn_next    = qn_reg;
        total_next = total_reg;
        len_next   = len_reg;
        wday_next  = wday_reg;
        cell_next  = cell_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    year_next  = s_tdata[YEAR_W-1:0];
                    month_next = s_tdata[YEAR_W +: MONTH_W];
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                qn_next    = prod_reg[RECIP_100_SHIFT +: 8];
                prod_next  = mul_p;
                state_next = ST_LEAP;
            end
            ST_LEAP:
            begin
                total_next = jan1_sum + MUL_A_W'(days_before(month_reg, leap));
                len_next   = month_length(month_reg, leap);
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                prod_next  = mul_p;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                wday_next  = rem7[WDAY_W-1:0];
                cell_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cell_next = cell_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            year_reg  <= '0;
            month_reg <= '0;
            prod_reg  <= '0;
            qn_reg    <= '0;
            total_reg <= '0;
            len_reg   <= '0;
            wday_reg  <= '0;
            cell_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            prod_reg  <= prod_next;
            qn_reg    <= qn_next;
            total_reg <= total_next;
            len_reg   <= len_next;
            wday_reg  <= wday_next;
            cell_reg  <= cell_next;
        end
    end

    // cell contents from the cell counter
    assign diff     = cell_reg - CELL_W'(wday_reg);
    assign in_month = (cell_reg >= CELL_W'(wday_reg)) && (diff < CELL_W'(len_reg));
    assign last     = (cell_reg == CELL_W'(GRID_CELLS - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {wday_reg, in_month ? (diff[DAY_W-1:0] + 5'd1) : 5'd0};
    assign m_tlast  = last;

endmodule

// ===== rtl/month_calendar_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// month_calendar_grid_checker: port-level checks for the calendar grid
// Watches the stream ports of the grid generator over time.
// ----------------------------------------------------------------------------
module month_calendar_grid_checker
    import mcg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] day_number, [7:5] first_weekday
    input  logic                  m_tlast    // last_cell
);

    // one request in work: never taking a request while cells are shown
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request taken while grid cells pending");

    // a taken request is not answered in the next cycle, and the block is busy then
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready))
        else $error("grid started without weekday computation");

    // after the last cell is taken the block is idle again
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after last grid cell");

    // first weekday is a real weekday and holds across the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:5] <= WDAY_SAT))
        else $error("first weekday out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && $past(m_tvalid)) |-> (m_tdata[7:5] == $past(m_tdata[7:5])))
        else $error("first weekday changed within a grid");

endmodule

bind month_calendar_grid month_calendar_grid_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_month_calendar_grid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_month_calendar_grid: self-checking bench for the month calendar grid
// Sends year and month requests and checks every grid cell that comes back,
// field by field, against a behavioral calendar model in the bench. It runs
// directed corner cases, then random requests with random idling on both
// sides, a long receiver hold-off and a stretch with no idling.
// ----------------------------------------------------------------------------
module tb_month_calendar_grid
    import mcg_pkg::*;
();

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 9;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int YEAR_MAX      = (1 << YEAR_W) - 1;
    localparam int MONTH_MAX     = (1 << MONTH_W) - 1;

    // one expected grid cell
    typedef struct packed {
        logic [DAY_W-1:0]  day_number;
        logic [WDAY_W-1:0] first_weekday;
        logic              last_cell;
    } grid_cell_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [13:0] year, [17:14] month, rest zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [4:0] day_number, [7:5] first_weekday
    logic                  m_tlast;         // last_cell

    grid_cell_t cells_due[$];
    int         mismatches  = 0;
    logic       tx_gaps     = 1'b1;
    logic       rx_gaps     = 1'b1;
    int         hold_ticket = 0;
    int         hold_taken  = 0;
    int         hold_left   = 0;
    int         quiet_cycles = 0;

    int unsigned days_in_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    month_calendar_grid i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // gregorian leap rule
    function automatic bit leap_year(input int unsigned yr);
        if (yr % 100 == 0)
        begin
            return (yr % 400) == 0;
        end
        return (yr % 4) == 0;
    endfunction

    // leap years in 1..n
    function automatic int unsigned leaps_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // weekday of january 1st, sunday is 0, years up to the base count as monday
    function automatic int unsigned new_year_weekday(input int unsigned yr);
        if (yr <= BASE_YEAR)
        begin
            return 1;
        end
        return (1 + (yr - BASE_YEAR) + leaps_through(yr - 1)
                - leaps_through(BASE_YEAR - 1)) % 7;
    endfunction

    // queue the 42 cells of one month grid
    function automatic void predict_month_grid(input logic [YEAR_W-1:0] yr,
                                               input logic [MONTH_W-1:0] mon);
        bit          leap;
        bit          real_month;
        int unsigned start_day;
        int unsigned span;
        int unsigned day;
        grid_cell_t  entry;
        leap       = leap_year(yr);
        real_month = (mon >= 1) && (mon <= 12);
        start_day  = new_year_weekday(yr);
        span       = 0;
        if (real_month)
        begin
            for (int m = 0; m + 1 < mon; m++)
            begin
                start_day += days_in_month[m];
                if (m == 1 && leap)
                begin
                    start_day += 1;
                end
            end
            start_day = start_day % 7;
            span = (mon == 2 && leap) ? 29 : days_in_month[mon - 1];
        end
        for (int k = 0; k < GRID_CELLS; k++)
        begin
            day = 0;
            if (real_month && k >= start_day && (k - start_day) < span)
            begin
                day = k - start_day + 1;
            end
            entry.day_number    = day[DAY_W-1:0];
            entry.first_weekday = start_day[WDAY_W-1:0];
            entry.last_cell     = (k == GRID_CELLS - 1);
            cells_due.push_back(entry);
        end
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mon);
        while (tx_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-YEAR_W-MONTH_W){1'b0}}, mon, yr};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_month_grid(yr, mon);
    endtask

    // stop offering and wait for every outstanding cell
    task automatic wait_all_cells();
        s_tvalid <= 1'b0;
        while (cells_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // corner years, every month, leap centuries, out of range codes
    task automatic test_directed();
        for (int m = 1; m <= 12; m++)
        begin
            send_request(YEAR_W'(BASE_YEAR), MONTH_W'(m));
        end
        send_request(14'd9999, MONTH_DEC);
        send_request(14'd2000, 4'd2);
        send_request(14'd2024, 4'd2);
        send_request(14'd2023, 4'd2);
        send_request(14'd1899, 4'd2);
        send_request(14'd0, MONTH_JAN);
        send_request(YEAR_W'(YEAR_MAX), 4'd2);
        send_request(14'd2021, 4'd0);
        send_request(14'd1901, 4'd13);
        send_request(YEAR_W'(YEAR_MAX), MONTH_W'(MONTH_MAX));
        send_request(14'd0, 4'd0);
        wait_all_cells();
    endtask

    // random requests, mostly valid dates with some out of range codes
    task automatic test_random(input int count);
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mon;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 80)
            begin
                yr = YEAR_W'($urandom_range(9999, BASE_YEAR));
            end
            else
            begin
                yr = YEAR_W'($urandom_range(YEAR_MAX, 0));
            end
            if ($urandom_range(99) < 90)
            begin
                mon = MONTH_W'($urandom_range(12, 1));
            end
            else
            begin
                mon = MONTH_W'($urandom_range(MONTH_MAX, 0));
            end
            send_request(yr, mon);
        end
        wait_all_cells();
    endtask

    // receiver holds off for a long time while requests keep coming
    task automatic test_backpressure();
        tx_gaps     = 1'b0;
        hold_ticket <= hold_ticket + 1;
        test_random(15);
        tx_gaps     = 1'b1;
    endtask

    // back to back requests with the receiver always ready
    task automatic test_full_rate();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random(40);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // stimulus sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(130);
        test_backpressure();
        test_full_rate();
        test_random(120);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && cells_due.size() == 0)
        begin
            $display("[month_calendar_grid] OK");
        end
        else
        begin
            $display("[month_calendar_grid] ERROR");
        end
        $finish;
    end

    // result checker and receiver ready
    always @(posedge clk)
    begin
        grid_cell_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cells_due.size() == 0)
                begin
                    $error("unexpected cell: day_number %0d first_weekday %0d last_cell %0b",
                           m_tdata[DAY_W-1:0], m_tdata[DAY_W+WDAY_W-1:DAY_W], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = cells_due.pop_front();
                    if (m_tdata[DAY_W-1:0] !== want.day_number)
                    begin
                        $error("day_number: expected %0d, actual %0d",
                               want.day_number, m_tdata[DAY_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[DAY_W+WDAY_W-1:DAY_W] !== want.first_weekday)
                    begin
                        $error("first_weekday: expected %0d, actual %0d",
                               want.first_weekday, m_tdata[DAY_W+WDAY_W-1:DAY_W]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last_cell)
                    begin
                        $error("last_cell: expected %0b, actual %0b",
                               want.last_cell, m_tlast);
                        mismatches++;
                    end
                end
            end
            // long hold-off when asked for, otherwise random idling
            if (hold_ticket != hold_taken)
            begin
                hold_taken = hold_ticket;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(99) < IDLE_PCT)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[month_calendar_grid] ERROR");
                $finish;
            end
        end
    end

endmodule
